FILE: rtl/gae_pkg.sv
// ----------------------------------------------------------------------------
// gae_pkg
// shared types, constants and header helpers for the gif application
// extension extractor
// ----------------------------------------------------------------------------
package gae_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned ID_W        = 64;
    localparam int unsigned AUTH_W      = 24;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned HPOS_W      = 4;
    localparam int unsigned USER_W      = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_APP_ID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTH   = 1'd1;

    localparam logic [ID_W-1:0]   APP_ID_RST = 64'd5783832781612199985;
    localparam logic [AUTH_W-1:0] AUTH_RST   = 24'd4344142;

    localparam logic [BYTE_W-1:0] INTRODUCER    = 8'h21;
    localparam logic [BYTE_W-1:0] APP_LABEL     = 8'hFF;
    localparam logic [BYTE_W-1:0] APP_BLOCK_LEN = 8'h0B;
    localparam logic [HPOS_W-1:0] HEADER_BYTES  = 4'd14;

    // status codes
    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic                byte_valid;
        logic                done;
        logic [STATUS_W-1:0] status;
    } t_result;

    // header data byte k: 0..7 from the id (first byte msb), 8..10 from auth code
    function automatic logic [BYTE_W-1:0] expected_byte(
        input logic [ID_W-1:0]   app_id,
        input logic [AUTH_W-1:0] auth,
        input logic [HPOS_W-1:0] k
    );
        logic [ID_W+AUTH_W-1:0] hdr;
        logic [BYTE_W-1:0]      sel;
        hdr = {app_id, auth};
        sel = '0;
        for (int i = 0; i < (ID_W + AUTH_W) / BYTE_W; i++) begin
            if (k == HPOS_W'(i)) begin
                sel = hdr[ID_W+AUTH_W-1-BYTE_W*i -: BYTE_W];
            end
        end
        return sel;
    endfunction

endpackage

FILE: rtl/gif_app_extension_extractor.sv
// ----------------------------------------------------------------------------
// gif_app_extension_extractor
// finds a gif application extension with a configured id and auth code and
// streams out the data bytes of its payload sub-blocks, one status per file
// ----------------------------------------------------------------------------
//
//  channel   dir  contents
//  s_axis    in   tdata[7:0] file byte, tlast final byte of the file
//  m_axis    out  tdata[7:0] payload byte, tuser[0] byte valid,
//                 tuser[2:1] status, tlast status result of the file
//  cfg       in   i_cfg_we / i_cfg_index / i_cfg_data, 0 app id, 1 auth code
//
//  one byte per cycle while s_axis_tready is high; the parse state updates in the cycle
//  a byte is taken and its result lands in the output or skid register on the same edge
//  s_axis_tready falls only while a second result waits in the skid stage,
//  i.e. after the output has been stalled with a result behind it
//  i_rst_n (synchronous, active low) returns the parser to scan and loads
//  the config registers with their default id and auth code
//
module gif_app_extension_extractor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte stream in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [gae_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] in_byte
    input  logic                          s_axis_tlast,   // end_of_data
    // result stream out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [gae_pkg::BYTE_W-1:0]    m_axis_tdata,   // [7:0] out_byte
    output logic [gae_pkg::USER_W-1:0]    m_axis_tuser,   // [0] byte_valid, [2:1] status
    output logic                          m_axis_tlast,   // done_res
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [gae_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gae_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gae_pkg::*;

    // parser modes
    localparam logic [2:0] M_SCAN      = 3'd0;
    localparam logic [2:0] M_LABEL     = 3'd1;
    localparam logic [2:0] M_SKIP_LEN  = 3'd2;
    localparam logic [2:0] M_SKIP_DATA = 3'd3;
    localparam logic [2:0] M_PAY_LEN   = 3'd4;
    localparam logic [2:0] M_PAY_DATA  = 3'd5;
    localparam logic [2:0] M_DRAIN     = 3'd6;

    // config registers
    logic [ID_W-1:0]   r_app_id;
    logic [AUTH_W-1:0] r_auth;

    // parse state
    logic [2:0]        r_mode,  n_mode;
    logic [HPOS_W-1:0] r_hpos,  n_hpos;
    logic              r_match, n_match;
    logic [BYTE_W-1:0] r_left,  n_left;

    // output register and skid stage
    t_result r_out, r_skid, n_res;
    logic    r_out_valid, r_skid_valid, n_res_valid;

    logic              s_take, m_take, last;
    logic [BYTE_W-1:0] b, left_dec;
    logic [BYTE_W-1:0] exp_byte;

    assign s_axis_tready = !r_skid_valid;
    assign s_take        = s_axis_tvalid && s_axis_tready;
    assign m_take        = m_axis_tvalid && m_axis_tready;
    assign b             = s_axis_tdata;
    assign last          = s_axis_tlast;
    assign left_dec      = r_left - BYTE_W'(1);
    // header position 2..12 compares id/auth bytes 0..10
    assign exp_byte      = expected_byte(r_app_id, r_auth, r_hpos - HPOS_W'(2));

    // ---------------- config ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_app_id <= APP_ID_RST;
            r_auth   <= AUTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_APP_ID: r_app_id <= i_cfg_data;
                REG_AUTH:   r_auth   <= i_cfg_data[AUTH_W-1:0];
                default:    ;
            endcase
        end
    end

    // ---------------- parser next state ----------------
    always_comb begin
        logic found_early;
        found_early  = 1'b0;
        n_mode       = r_mode;
        n_hpos       = r_hpos;
        n_match      = r_match;
        n_left       = r_left;
        n_res        = '0;

        unique case (r_mode)
            M_LABEL: begin
                // label byte is not used to pick the walk, only compared
                n_match = (b == APP_LABEL);
                n_hpos  = HPOS_W'(1);
                n_mode  = M_SKIP_LEN;
                if (last) begin
                    n_res.done   = 1'b1;
                    n_res.status = ST_NO_MATCH;
                end
            end
            M_SKIP_LEN: begin
                if (r_hpos == HPOS_W'(1)) begin
                    n_match = r_match && (b == APP_BLOCK_LEN);
                    n_hpos  = HPOS_W'(2);
                end
                if (b == '0) begin
                    n_mode = M_SCAN;
                end else begin
                    n_left = b;
                    n_mode = M_SKIP_DATA;
                end
                if (last) begin
                    n_res.done   = 1'b1;
                    n_res.status = ST_NO_MATCH;
                end
            end
            M_SKIP_DATA: begin
                if (r_hpos >= HPOS_W'(2) && r_hpos < HEADER_BYTES - HPOS_W'(1)) begin
                    n_match = r_match && (b == exp_byte);
                    n_hpos  = r_hpos + HPOS_W'(1);
                end
                n_left = left_dec;
                if (left_dec == '0) begin
                    // whole header seen and matched: payload sub-blocks follow
                    if (n_match && n_hpos == HEADER_BYTES - HPOS_W'(1)) begin
                        n_mode = M_PAY_LEN;
                    end else begin
                        n_mode = M_SKIP_LEN;
                    end
                end
                if (last) begin
                    n_res.done   = 1'b1;
                    n_res.status = (n_mode == M_PAY_LEN) ? ST_FOUND : ST_NO_MATCH;
                end
            end
            M_PAY_LEN: begin
                if (b == '0) begin
                    // terminator: report now, drain the rest of the file
                    n_res.done   = 1'b1;
                    n_res.status = ST_FOUND;
                    found_early  = 1'b1;
                end else begin
                    n_left = b;
                    n_mode = M_PAY_DATA;
                    if (last) begin
                        n_res.done   = 1'b1;
                        n_res.status = ST_TRUNC;
                    end
                end
            end
            M_PAY_DATA: begin
                n_res.data       = b;
                n_res.byte_valid = 1'b1;
                n_left           = left_dec;
                if (left_dec == '0) begin
                    n_mode = M_PAY_LEN;
                end
                if (last) begin
                    n_res.done   = 1'b1;
                    n_res.status = (left_dec == '0) ? ST_FOUND : ST_TRUNC;
                end
            end
            M_DRAIN: begin
            end
            default: begin
                // scan, and the unused code
                if (b == INTRODUCER) begin
                    n_mode  = M_LABEL;
                    n_hpos  = '0;
                    n_match = 1'b1;
                end
                if (last) begin
                    n_res.done   = 1'b1;
                    n_res.status = ST_NO_MATCH;
                end
            end
        endcase

        // end of file resets everything for the next file
        if (last) begin
            n_mode  = M_SCAN;
            n_hpos  = '0;
            n_match = 1'b1;
            n_left  = '0;
        end else if (found_early) begin
            n_mode  = M_DRAIN;
            n_hpos  = '0;
            n_match = 1'b1;
            n_left  = '0;
        end

        n_res_valid = n_res.byte_valid || n_res.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_SCAN;
            r_hpos  <= '0;
            r_match <= 1'b1;
            r_left  <= '0;
        end else if (s_take) begin
            r_mode  <= n_mode;
            r_hpos  <= n_hpos;
            r_match <= n_match;
            r_left  <= n_left;
        end
    end

    // ---------------- output register with skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_take) begin
            if (r_skid_valid) begin
                // input is held off while the skid is full
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= s_take && n_res_valid;
            end
        end else if (s_take && n_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_take) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (s_take && n_res_valid) begin
            r_skid <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.data;
    assign m_axis_tlast  = r_out.done;
    assign m_axis_tuser  = {{(USER_W-STATUS_W-1){1'b0}}, r_out.status, r_out.byte_valid};

    // ---------------- assertions ----------------
    // the skid stage only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result with the output register empty");

    // every result carries a byte or a status
    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tlast))
        else $error("empty result on the output");

    // status is zero except on the final result of a file
    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser[2:1] == ST_FOUND))
        else $error("status set on a result that is not final");

    // the final byte of a file leaves the parser in scan
    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_take && s_axis_tlast) |=> (r_mode == M_SCAN && r_left == '0))
        else $error("parser not cleared after end of file");

endmodule
